// ===== sv/button_gesture_decoder_top_macros.svh =====
// Assertion macros shared by the button gesture decoder RTL.
`ifndef BUTTON_GESTURE_DECODER_TOP_MACROS_SVH
`define BUTTON_GESTURE_DECODER_TOP_MACROS_SVH

// Implication checked in the same cycle.
`define BGD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the next cycle.
`define BGD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/bgd_pkg.sv =====
// Types and constants of the button gesture decoder.
package bgd_pkg;

	localparam int unsigned CFG_W     = 16;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE     = 2'd0,
		CFG_SELECT_HOLD  = 2'd1,
		CFG_BACK_HOLD    = 2'd2,
		CFG_DOUBLE_CLICK = 2'd3
	} cfg_idx_t;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST     = 16'd75;
	localparam logic [CFG_W-1:0] SELECT_HOLD_RST  = 16'd550;
	localparam logic [CFG_W-1:0] BACK_HOLD_RST    = 16'd1200;
	localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 16'd300;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] select_hold_ms;
		logic [CFG_W-1:0] back_hold_ms;
		logic [CFG_W-1:0] double_click_ms;
	} cfg_t;

	typedef enum logic [1:0] {
		LVL_BACK = 2'd0,
		LVL_SEL  = 2'd1,
		LVL_NONE = 2'd2
	} band_lvl_t;

	typedef enum logic [1:0] {
		BAND_NOP       = 2'd0,
		BAND_DRAW_SEL  = 2'd1,
		BAND_DRAW_BACK = 2'd2,
		BAND_CLEAR     = 2'd3
	} band_code_t;

	localparam logic [1:0] CLICK_MAX = 2'd3;
	localparam logic [1:0] CLICK_DBL = 2'd2;

	typedef struct packed {
		logic       next_press;
		logic       prev_press;
		logic       sel_press;
		logic       esc_press;
		logic       any_key;
		logic       long_hold;
		band_code_t band_update;
	} res_t;

endpackage

// ===== sv/bgd_ifs.sv =====
// Request and result channel interfaces of the button gesture decoder.
interface bgd_req_if;
	logic        valid;
	logic        ready;
	logic        button_down;
	logic [31:0] now_ms;

	modport source (output valid, button_down, now_ms, input ready);
	modport sink (input valid, button_down, now_ms, output ready);
endinterface

interface bgd_res_if;
	logic       valid;
	logic       ready;
	logic       next_press;
	logic       prev_press;
	logic       sel_press;
	logic       esc_press;
	logic       any_key;
	logic       long_hold;
	logic [1:0] band_update;

	modport source (output valid, next_press, prev_press, sel_press, esc_press, any_key,
		long_hold, band_update, input ready);
	modport sink (input valid, next_press, prev_press, sel_press, esc_press, any_key,
		long_hold, band_update, output ready);
endinterface

// ===== sv/button_gesture_decoder_top.sv =====
// Top level of the button gesture decoder: sample stage, decode core, result register.
// A request in the sample stage moves to the result register once that is empty or being read.
// Throughput: one request per cycle while results drain; gesture state steps per advance.
// While a finished result waits, the sample stage can still take one request.
// Reset: asynchronous, active low; gesture state, valid flags and config return to defaults.
`include "button_gesture_decoder_top_macros.svh"

module button_gesture_decoder_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bgd_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [bgd_pkg::CFG_W-1:0]     cfg_wdata,
	bgd_req_if.sink                       req,
	bgd_res_if.source                     result
);

	bgd_pkg::cfg_t              cfg;
	bgd_pkg::res_t              res_d;
	bgd_pkg::res_t              res_q;
	logic                       valid_s1;
	logic                       button_down_s1;
	logic [bgd_pkg::TIME_W-1:0] now_ms_s1;
	logic                       out_valid_q;
	logic                       advance;
	logic                       take;

	assign advance   = valid_s1 && (!out_valid_q || result.ready);
	assign req.ready = !valid_s1 || advance;
	assign take      = req.valid && req.ready;

	bgd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bgd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.button_down (button_down_s1),
		.now_ms      (now_ms_s1),
		.cfg         (cfg),
		.res         (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			button_down_s1 <= req.button_down;
			now_ms_s1      <= req.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.next_press  = res_q.next_press;
	assign result.prev_press  = res_q.prev_press;
	assign result.sel_press   = res_q.sel_press;
	assign result.esc_press   = res_q.esc_press;
	assign result.any_key     = res_q.any_key;
	assign result.long_hold   = res_q.long_hold;
	assign result.band_update = res_q.band_update;

	`BGD_ASSERT_NEXT(a_adv_fills_out, clk, arst_n, advance, out_valid_q, "result lost after advance")
	`BGD_ASSERT_NOW(a_no_overrun, clk, arst_n, take, !valid_s1 || advance, "request overwrote stage")
	`BGD_ASSERT_NOW(a_one_release, clk, arst_n, out_valid_q, !(res_q.sel_press && res_q.esc_press), "select and back together")

endmodule

// ===== sv/bgd_cfg_regs.sv =====
// Configuration register file of the button gesture decoder.
module bgd_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bgd_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [bgd_pkg::CFG_W-1:0]     cfg_wdata,
	output bgd_pkg::cfg_t                 cfg
);

	bgd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms     <= bgd_pkg::DEBOUNCE_RST;
			cfg_q.select_hold_ms  <= bgd_pkg::SELECT_HOLD_RST;
			cfg_q.back_hold_ms    <= bgd_pkg::BACK_HOLD_RST;
			cfg_q.double_click_ms <= bgd_pkg::DOUBLE_CLICK_RST;
		end else if (cfg_we) begin
			case (bgd_pkg::cfg_idx_t'(cfg_addr))
				bgd_pkg::CFG_DEBOUNCE: begin
					cfg_q.debounce_ms <= cfg_wdata;
				end
				bgd_pkg::CFG_SELECT_HOLD: begin
					cfg_q.select_hold_ms <= cfg_wdata;
				end
				bgd_pkg::CFG_BACK_HOLD: begin
					cfg_q.back_hold_ms <= cfg_wdata;
				end
				bgd_pkg::CFG_DOUBLE_CLICK: begin
					cfg_q.double_click_ms <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/bgd_core.sv =====
// Gesture state and per-sample decode logic of the button gesture decoder.
`include "button_gesture_decoder_top_macros.svh"

module bgd_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic                       button_down,
	input  logic [bgd_pkg::TIME_W-1:0] now_ms,
	input  bgd_pkg::cfg_t              cfg,
	output bgd_pkg::res_t              res
);

	logic                       was_down_q;
	logic [bgd_pkg::TIME_W-1:0] press_time_q;
	logic                       long_flag_q;
	bgd_pkg::band_lvl_t         band_level_q;
	logic [bgd_pkg::TIME_W-1:0] release_time_q;
	logic [1:0]                 click_count_q;
	logic                       pending_q;

	logic                       was_down_d;
	logic [bgd_pkg::TIME_W-1:0] press_time_d;
	logic                       long_flag_d;
	bgd_pkg::band_lvl_t         band_level_d;
	logic [bgd_pkg::TIME_W-1:0] release_time_d;
	logic [1:0]                 click_count_d;
	logic                       pending_d;

	logic [bgd_pkg::TIME_W-1:0] since_press;
	logic [bgd_pkg::TIME_W-1:0] since_release;
	logic [bgd_pkg::TIME_W-1:0] held;
	logic                       ignore;
	logic                       rel_expired;
	logic                       press_edge;
	logic                       sel_hit;
	logic                       back_hit;
	logic [1:0]                 clicks;

	assign since_press   = now_ms - press_time_q;
	assign since_release = now_ms - release_time_q;
	assign ignore        = (since_press < {16'd0, cfg.debounce_ms}) && !long_flag_q;
	assign rel_expired   = since_release > {16'd0, cfg.double_click_ms};
	assign press_edge    = button_down && !was_down_q;
	assign held          = press_edge ? '0 : since_press;
	assign sel_hit       = held >= {16'd0, cfg.select_hold_ms};
	assign back_hit      = held >= {16'd0, cfg.back_hold_ms};

	always_comb begin
		was_down_d     = was_down_q;
		press_time_d   = press_time_q;
		long_flag_d    = long_flag_q;
		band_level_d   = band_level_q;
		release_time_d = release_time_q;
		click_count_d  = click_count_q;
		pending_d      = pending_q;
		clicks         = click_count_q;
		res            = '0;
		res.band_update = bgd_pkg::BAND_NOP;

		if (ignore) begin
			res.long_hold = long_flag_q;
		end else begin
			if (pending_q && rel_expired) begin
				res.next_press = 1'b1;
				pending_d      = 1'b0;
			end

			if (button_down) begin
				was_down_d  = 1'b1;
				res.any_key = 1'b1;
				if (press_edge) begin
					press_time_d = now_ms;
				end
				long_flag_d = (press_edge ? 1'b0 : long_flag_q) | sel_hit;
				if (sel_hit && band_level_q == bgd_pkg::LVL_NONE) begin
					band_level_d    = bgd_pkg::LVL_SEL;
					res.band_update = bgd_pkg::BAND_DRAW_SEL;
				end
				if (back_hit && band_level_q != bgd_pkg::LVL_BACK) begin
					band_level_d    = bgd_pkg::LVL_BACK;
					res.band_update = bgd_pkg::BAND_DRAW_BACK;
				end
			end else if (was_down_q) begin
				was_down_d      = 1'b0;
				band_level_d    = bgd_pkg::LVL_NONE;
				res.band_update = bgd_pkg::BAND_CLEAR;
				res.any_key     = 1'b1;
				long_flag_d     = 1'b0;
				if (rel_expired) begin
					clicks = '0;
				end
				click_count_d = clicks;
				if (back_hit) begin
					res.esc_press = 1'b1;
					pending_d     = 1'b0;
				end else if (sel_hit) begin
					res.sel_press = 1'b1;
					pending_d     = 1'b0;
				end else begin
					release_time_d = now_ms;
					if (clicks != bgd_pkg::CLICK_MAX) begin
						clicks = clicks + 2'd1;
					end
					if (clicks >= bgd_pkg::CLICK_DBL) begin
						res.prev_press = 1'b1;
						click_count_d  = '0;
						pending_d      = 1'b0;
					end else begin
						click_count_d = clicks;
						pending_d     = 1'b1;
					end
				end
			end
			res.long_hold = long_flag_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_down_q     <= 1'b0;
			press_time_q   <= '0;
			long_flag_q    <= 1'b0;
			band_level_q   <= bgd_pkg::LVL_NONE;
			release_time_q <= '0;
			click_count_q  <= '0;
			pending_q      <= 1'b0;
		end else if (advance) begin
			was_down_q     <= was_down_d;
			press_time_q   <= press_time_d;
			long_flag_q    <= long_flag_d;
			band_level_q   <= band_level_d;
			release_time_q <= release_time_d;
			click_count_q  <= click_count_d;
			pending_q      <= pending_d;
		end
	end

	`BGD_ASSERT_NOW(a_long_needs_down, clk, arst_n, long_flag_q, was_down_q, "long hold without press")
	`BGD_ASSERT_NOW(a_click_low, clk, arst_n, 1'b1, click_count_q <= 2'd1, "click count above one")
	`BGD_ASSERT_NOW(a_band_idle, clk, arst_n, !was_down_q, band_level_q == bgd_pkg::LVL_NONE, "band drawn while released")

endmodule
